@@ rtl/core/gast_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gast_pkg: shared types and constants for the gimbal slew tracker
// Binary-angle types, item structs, register indexes and the fixed-point
// constants used by the target former and the per-axis step logic.
// ----------------------------------------------------------------------------
package gast_pkg;

	// 16-bit binary angle, 32768 stands for pi
	localparam int ANGLE_W = 16;
	typedef logic signed [ANGLE_W-1:0] angle_t;

	// Q1.14 trig registers
	localparam int Q_FRAC = 14;
	localparam int PROD_W = 2 * ANGLE_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1 << (Q_FRAC - 1));

	// Step limit width
	localparam int STEP_W = 15;
	typedef logic [STEP_W-1:0] step_t;

	// Divide by 50 as multiply by reciprocal (exact for magnitudes up to 32768)
	localparam int STEP_DIV    = 50;
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + STEP_DIV - 1) / STEP_DIV;
	localparam int MAG_W       = ANGLE_W + 1;
	localparam int QUOT_W      = 10;

	// Input item
	typedef struct packed {
		angle_t handle_yaw;
		angle_t handle_pitch;
		angle_t handle_roll;
	} sample_t;

	// Result item
	typedef struct packed {
		angle_t camera_yaw;
		angle_t camera_pitch;
		angle_t camera_roll;
	} camera_t;

	// Tracking modes; the unused code behaves as full follow
	typedef enum logic [1:0] {
		MODE_HORIZON = 2'd0,
		MODE_FOLLOW  = 2'd1,
		MODE_FULL    = 2'd2
	} mode_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE          = 3'd0,
		REG_YAW_OFFSET    = 3'd1,
		REG_PITCH_OFFSET  = 3'd2,
		REG_ROLL_OFFSET   = 3'd3,
		REG_OFFSET_SINE   = 3'd4,
		REG_OFFSET_COSINE = 3'd5,
		REG_MAX_STEP      = 3'd6
	} cfg_idx_t;

	// Reset values
	localparam logic [1:0]   MODE_RESET     = MODE_FOLLOW;
	localparam angle_t       COSINE_RESET   = angle_t'(16384);
	localparam step_t        MAX_STEP_RESET = step_t'(328);

endpackage
`default_nettype wire

@@ rtl/core/gast_axis_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gast_axis_step: one axis slew step
// Wrapped target error, truncating divide by 50, clamp to the step limit,
// and wrapped add onto the current angle.
// ----------------------------------------------------------------------------
module gast_axis_step (
	input  gast_pkg::angle_t current,
	input  gast_pkg::angle_t target,
	input  gast_pkg::step_t  max_step,
	output gast_pkg::angle_t next_angle
);
	import gast_pkg::*;

	angle_t                diff;
	logic signed [MAG_W-1:0] diff_ext;
	logic [MAG_W-1:0]      mag;
	logic [SUM_W-1:0]      prod;
	logic [QUOT_W-1:0]     quot;
	step_t                 quot_ext;
	step_t                 lim;
	angle_t                step_pos;
	angle_t                step;

	// Wrapped error and its magnitude (pi gives 32768)
	always_comb begin
		diff     = target - current;
		diff_ext = MAG_W'(diff);
		mag      = diff[ANGLE_W-1] ? MAG_W'(-diff_ext) : MAG_W'(diff_ext);
	end

	// Magnitude / 50 by reciprocal multiply, then clamp
	always_comb begin
		prod     = SUM_W'(mag) * SUM_W'(RECIP_MUL);
		quot     = prod[RECIP_SHIFT +: QUOT_W];
		quot_ext = STEP_W'(quot);
		lim      = (quot_ext > max_step) ? max_step : quot_ext;
	end

	// Restore sign and move
	always_comb begin
		step_pos   = angle_t'({1'b0, lim});
		step       = diff[ANGLE_W-1] ? -step_pos : step_pos;
		next_angle = current + step;
	end

endmodule
`default_nettype wire

@@ rtl/core/gimbal_attitude_slew_tracker_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gimbal_attitude_slew_tracker_core: camera angle slew tracker
// Forms camera targets from handle attitude samples and moves the kept
// camera angles toward them by a limited step per sample.
// ----------------------------------------------------------------------------
// Each accepted handle sample yields exactly one item of updated camera angles.
// The block takes one item per clock when the output is not stalled; each item
// passes the input register, the target register and the output register. The
// target stage holds four 16x16 multipliers for the yaw-offset rotation; the
// per-axis step (subtract, reciprocal divide by 50, clamp, add) closes the loop
// on the current-angle registers combinationally, which sets the one-item
// per clock rate. Configuration writes are always ready and must only be made
// while no item is in flight.
// ----------------------------------------------------------------------------
module gimbal_attitude_slew_tracker_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  gast_pkg::sample_t                   in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output gast_pkg::camera_t                   out_data,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [gast_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [gast_pkg::ANGLE_W-1:0]         cfg_data
);
	import gast_pkg::*;

	// Configuration registers
	logic [1:0] mode_q;
	angle_t     yaw_offset_q;
	angle_t     pitch_offset_q;
	angle_t     roll_offset_q;
	angle_t     sine_q;
	angle_t     cosine_q;
	step_t      max_step_q;

	// Pipeline
	logic    valid_s1;
	sample_t sample_s1;
	logic    valid_s2;
	angle_t  tgt_yaw_s2;
	angle_t  tgt_pitch_s2;
	angle_t  tgt_roll_s2;
	logic    out_valid_q;
	angle_t  cur_yaw_q;
	angle_t  cur_pitch_q;
	angle_t  cur_roll_q;

	// Handshake
	logic adv_s1;
	logic adv_s2;
	logic adv_out;

	// Target forming
	logic signed [PROD_W-1:0] prod_cp;
	logic signed [PROD_W-1:0] prod_sr;
	logic signed [PROD_W-1:0] prod_cr;
	logic signed [PROD_W-1:0] prod_sp;
	logic signed [SUM_W-1:0]  pitch_sum;
	logic signed [SUM_W-1:0]  roll_sum;
	angle_t                   pitch_term;
	angle_t                   roll_term;
	logic                     pitch_on;
	logic                     roll_on;
	angle_t                   tgt_yaw;
	angle_t                   tgt_pitch;
	angle_t                   tgt_roll;

	// Step results
	angle_t nxt_yaw;
	angle_t nxt_pitch;
	angle_t nxt_roll;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_RESET;
			yaw_offset_q   <= '0;
			pitch_offset_q <= '0;
			roll_offset_q  <= '0;
			sine_q         <= '0;
			cosine_q       <= COSINE_RESET;
			max_step_q     <= MAX_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:          mode_q         <= cfg_data[1:0];
				REG_YAW_OFFSET:    yaw_offset_q   <= angle_t'(cfg_data);
				REG_PITCH_OFFSET:  pitch_offset_q <= angle_t'(cfg_data);
				REG_ROLL_OFFSET:   roll_offset_q  <= angle_t'(cfg_data);
				REG_OFFSET_SINE:   sine_q         <= angle_t'(cfg_data);
				REG_OFFSET_COSINE: cosine_q       <= angle_t'(cfg_data);
				REG_MAX_STEP:      max_step_q     <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage advance, bubbles collapse
	always_comb begin
		adv_out  = !out_valid_q || !out_stall;
		adv_s2   = !valid_s2 || adv_out;
		adv_s1   = !valid_s1 || adv_s2;
		in_stall = !adv_s1;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)  valid_s1    <= in_valid;
			if (adv_s2)  valid_s2    <= valid_s1;
			if (adv_out) out_valid_q <= valid_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			sample_s1 <= in_data;
		end
	end

	// Rotation by yaw offset, Q1.14 round-half-up, mode gating
	always_comb begin
		prod_cp   = cosine_q * sample_s1.handle_pitch;
		prod_sr   = sine_q * sample_s1.handle_roll;
		prod_cr   = cosine_q * sample_s1.handle_roll;
		prod_sp   = sine_q * sample_s1.handle_pitch;
		pitch_sum = SUM_W'(prod_cp) - SUM_W'(prod_sr) + ROUND_BIAS;
		roll_sum  = SUM_W'(prod_cr) + SUM_W'(prod_sp) + ROUND_BIAS;
		pitch_on  = (mode_q != MODE_HORIZON);
		roll_on   = (mode_q != MODE_HORIZON) && (mode_q != MODE_FOLLOW);
		pitch_term = pitch_on ? pitch_sum[Q_FRAC +: ANGLE_W] : '0;
		roll_term  = roll_on ? roll_sum[Q_FRAC +: ANGLE_W] : '0;
		tgt_yaw    = sample_s1.handle_yaw + yaw_offset_q;
		tgt_pitch  = pitch_term + pitch_offset_q;
		tgt_roll   = roll_term - roll_offset_q;
	end

	// Target register
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			tgt_yaw_s2   <= tgt_yaw;
			tgt_pitch_s2 <= tgt_pitch;
			tgt_roll_s2  <= tgt_roll;
		end
	end

	// Per-axis slew steps
	gast_axis_step u_step_yaw (
		.current    (cur_yaw_q),
		.target     (tgt_yaw_s2),
		.max_step   (max_step_q),
		.next_angle (nxt_yaw)
	);

	gast_axis_step u_step_pitch (
		.current    (cur_pitch_q),
		.target     (tgt_pitch_s2),
		.max_step   (max_step_q),
		.next_angle (nxt_pitch)
	);

	gast_axis_step u_step_roll (
		.current    (cur_roll_q),
		.target     (tgt_roll_s2),
		.max_step   (max_step_q),
		.next_angle (nxt_roll)
	);

	// Current angles double as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_yaw_q   <= '0;
			cur_pitch_q <= '0;
			cur_roll_q  <= '0;
		end else if (valid_s2 && adv_out) begin
			cur_yaw_q   <= nxt_yaw;
			cur_pitch_q <= nxt_pitch;
			cur_roll_q  <= nxt_roll;
		end
	end

	// Output item
	always_comb begin
		out_valid             = out_valid_q;
		out_data.camera_yaw   = cur_yaw_q;
		out_data.camera_pitch = cur_pitch_q;
		out_data.camera_roll  = cur_roll_q;
	end

endmodule
`default_nettype wire

@@ verif/gast_slew_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gast_slew_checker: camera angle predictor and result comparator
// Follows the register writes, works out the camera angles that each accepted
// handle sample should produce and compares every accepted result item, field
// by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gast_slew_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  wire                           in_stall,
	input  gast_pkg::sample_t             in_data,
	input  wire                           out_valid,
	input  wire                           out_stall,
	input  gast_pkg::camera_t             out_data,
	input  wire                           cfg_valid,
	input  wire                           cfg_ready,
	input  wire [gast_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [gast_pkg::ANGLE_W-1:0]   cfg_data,
	output int                            awaited,
	output int                            errors
);
	import gast_pkg::*;

	// Shadow copy of the register file
	logic [1:0] mode_q;
	angle_t     yaw_off;
	angle_t     pitch_off;
	angle_t     roll_off;
	angle_t     sin_q;
	angle_t     cos_q;
	step_t      lim_step;

	// Kept camera angles and the predictions still owed by the block
	camera_t    cam_now;
	camera_t    cam_expected[$];
	camera_t    aim;
	camera_t    want;
	int         n_seen;

	task automatic flag_error(input string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input angle_t got, input angle_t exp_val);
		if (got !== exp_val)
			flag_error($sformatf("result %0d %s: got %0d, expected %0d",
				n_seen, name, got, exp_val));
	endtask

	// floor((acc + 2^13) / 2^14), wrapped to an angle
	function automatic angle_t rounded_q14(input longint acc);
		return angle_t'((acc + (longint'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC);
	endfunction

	// Target angles for one handle sample under the current registers
	function automatic camera_t aim_for(input sample_t s);
		camera_t t;
		angle_t  pitch_term;
		angle_t  roll_term;
		longint  hp;
		longint  hr;
		hp = longint'(s.handle_pitch);
		hr = longint'(s.handle_roll);
		pitch_term = '0;
		roll_term  = '0;
		// horizon drops both terms, follow drops only roll
		if (mode_q != MODE_HORIZON)
			pitch_term = rounded_q14(longint'(cos_q) * hp - longint'(sin_q) * hr);
		if (mode_q != MODE_HORIZON && mode_q != MODE_FOLLOW)
			roll_term = rounded_q14(longint'(cos_q) * hr + longint'(sin_q) * hp);
		t.camera_yaw   = s.handle_yaw + yaw_off;
		t.camera_pitch = pitch_term + pitch_off;
		t.camera_roll  = roll_term - roll_off;
		return t;
	endfunction

	// One limited move of a kept angle toward its target, all in 16-bit wrap
	function automatic angle_t step_axis(input angle_t now, input angle_t target);
		angle_t gap;
		int     move;
		gap  = target - now;
		move = int'(gap) / STEP_DIV;
		if (move > int'(lim_step))
			move = int'(lim_step);
		if (move < -int'(lim_step))
			move = -int'(lim_step);
		return angle_t'(int'(now) + move);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    = MODE_RESET;
			yaw_off   = '0;
			pitch_off = '0;
			roll_off  = '0;
			sin_q     = '0;
			cos_q     = COSINE_RESET;
			lim_step  = MAX_STEP_RESET;
			cam_now   = '0;
			cam_expected.delete();
			awaited   = 0;
			n_seen    = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:          mode_q    = cfg_data[1:0];
					REG_YAW_OFFSET:    yaw_off   = cfg_data;
					REG_PITCH_OFFSET:  pitch_off = cfg_data;
					REG_ROLL_OFFSET:   roll_off  = cfg_data;
					REG_OFFSET_SINE:   sin_q     = cfg_data;
					REG_OFFSET_COSINE: cos_q     = cfg_data;
					REG_MAX_STEP:      lim_step  = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end

			// result items, compared in order
			if (out_valid && !out_stall) begin
				if (cam_expected.size() == 0) begin
					flag_error($sformatf("result %0d arrived with nothing outstanding",
						n_seen));
				end else begin
					want = cam_expected.pop_front();
					check_field("camera_yaw",   out_data.camera_yaw,   want.camera_yaw);
					check_field("camera_pitch", out_data.camera_pitch, want.camera_pitch);
					check_field("camera_roll",  out_data.camera_roll,  want.camera_roll);
				end
				n_seen++;
			end

			// handle samples advance the kept angles
			if (in_valid && !in_stall) begin
				aim = aim_for(in_data);
				cam_now.camera_yaw   = step_axis(cam_now.camera_yaw,   aim.camera_yaw);
				cam_now.camera_pitch = step_axis(cam_now.camera_pitch, aim.camera_pitch);
				cam_now.camera_roll  = step_axis(cam_now.camera_roll,  aim.camera_roll);
				cam_expected.push_back(cam_now);
			end

			awaited = cam_expected.size();
		end
	end

endmodule

@@ verif/tb_gimbal_attitude_slew_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gimbal_attitude_slew_tracker_core: slew tracker regression
// Drives handle samples and register settings into the tracker with random
// gaps and output stalls; the checker beside the block predicts and compares
// every camera angle item, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_gimbal_attitude_slew_tracker_core;
	import gast_pkg::*;

	// unused mode code, behaves as full follow
	localparam logic [1:0]           MODE_SPARE  = 2'd3;
	// index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
	localparam int                   IDLE_LIMIT  = 4000;
	localparam int                   PHASES      = 8;
	localparam int                   PHASE_ITEMS = 180;
	localparam int                   CALM_PHASE  = 3;
	localparam int                   SETTLE      = 8;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	sample_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	camera_t              out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ANGLE_W-1:0]   cfg_data  = '0;

	bit                   calm;
	int                   awaited;
	int                   errors;

	always #4 clk = ~clk;

	gimbal_attitude_slew_tracker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gast_slew_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.awaited   (awaited),
		.errors    (errors)
	);

	// Present one handle sample, after a random gap outside the calm phase, hold it until taken
	task automatic send_sample(input angle_t y, input angle_t p, input angle_t r);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{handle_yaw: y, handle_pitch: p, handle_roll: r};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Write the whole register file; unused data bits get random values
	task automatic load_config(input logic [1:0] m, input angle_t yo, input angle_t po,
		input angle_t ro, input angle_t sn, input angle_t cs, input step_t ms);
		logic [ANGLE_W-1:0] word;
		word      = ANGLE_W'($urandom);
		word[1:0] = m;
		cfg_write(REG_MODE, word);
		cfg_write(REG_YAW_OFFSET, yo);
		cfg_write(REG_PITCH_OFFSET, po);
		cfg_write(REG_ROLL_OFFSET, ro);
		cfg_write(REG_OFFSET_SINE, sn);
		cfg_write(REG_OFFSET_COSINE, cs);
		word = {1'($urandom), ms};
		cfg_write(REG_MAX_STEP, word);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait for every outstanding item to come back
	task automatic hold_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited != 0)
			@(negedge clk);
	endtask

	// Output back-pressure
	initial begin
		forever begin
			@(negedge clk);
			out_stall <= !calm && ($urandom_range(0, 99) < 30);
		end
	end

	// Watchdog on cycles with no handshake on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		angle_t     y;
		angle_t     p;
		angle_t     r;
		int         span;
		logic [1:0] m;
		angle_t     sn;
		angle_t     cs;
		step_t      ms;

		calm = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings; first sample sits exactly pi away on yaw and pitch
		send_sample(-32768, -32768, -32768);
		send_sample(32767, 32767, 32767);
		send_sample(0, 0, 0);
		send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
		send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);

		// full follow, extreme offsets, no step clamp in reach
		hold_until_drained();
		load_config(MODE_FULL, 32767, -32768, -32768, 16384, -16384, 32767);
		send_sample(32767, -32768, 32767);
		send_sample(-32768, 32767, -32768);
		send_sample(0, 0, 0);
		send_sample(12345, -2222, 777);

		// spare mode code, trig values past one, frozen angles
		hold_until_drained();
		cfg_write(REG_UNUSED, ANGLE_W'($urandom));
		load_config(MODE_SPARE, 0, 0, 0, -32768, 32767, 0);
		send_sample(32767, 32767, -32768);
		send_sample(-32768, -32768, 32767);
		send_sample(1, -1, 1);

		// horizon, unit step, 45 degree offset
		hold_until_drained();
		load_config(MODE_HORIZON, -1, 1, 1, 11585, 11585, 1);
		send_sample(-32768, 32767, -32768);
		send_sample(32767, -32768, 32767);
		send_sample(-1, 1, -1);

		// random phases: mostly slow handle motion, some wild samples
		for (int ph = 0; ph < PHASES; ph++) begin
			hold_until_drained();
			calm = (ph == CALM_PHASE);
			m = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 4) != 0) begin
				sn = angle_t'(int'($urandom_range(0, 32768)) - 16384);
				cs = angle_t'(int'($urandom_range(0, 32768)) - 16384);
			end else begin
				sn = angle_t'($urandom);
				cs = angle_t'($urandom);
			end
			case ($urandom_range(0, 5))
				0:       ms = '0;
				1:       ms = step_t'(1);
				2:       ms = step_t'($urandom_range(2, 60));
				3:       ms = MAX_STEP_RESET;
				4:       ms = '1;
				default: ms = step_t'($urandom);
			endcase
			load_config(m, angle_t'($urandom), angle_t'($urandom), angle_t'($urandom),
				sn, cs, ms);

			case ($urandom_range(0, 2))
				0:       span = 4;
				1:       span = 150;
				default: span = 2500;
			endcase
			y = angle_t'($urandom);
			p = angle_t'($urandom);
			r = angle_t'($urandom);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 25) begin
					send_sample(angle_t'($urandom), angle_t'($urandom), angle_t'($urandom));
				end else begin
					if ($urandom_range(0, 99) < 3) begin
						y = angle_t'($urandom);
						p = angle_t'($urandom);
						r = angle_t'($urandom);
					end
					y = angle_t'(int'(y) + int'($urandom_range(0, 2 * span)) - span);
					p = angle_t'(int'(p) + int'($urandom_range(0, 2 * span)) - span);
					r = angle_t'(int'(r) + int'($urandom_range(0, 2 * span)) - span);
					send_sample(y, p, r);
				end
			end
		end

		hold_until_drained();
		calm = 1'b0;
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && awaited == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/gast_pkg.sv
rtl/core/gast_axis_step.sv
rtl/core/gimbal_attitude_slew_tracker_core.sv
verif/gast_slew_checker.sv
verif/tb_gimbal_attitude_slew_tracker_core.sv
